[design/bezier_position_smoother_assert.svh]
// Assertion macros shared by the checker of the position smoother.
`ifndef BEZIER_POSITION_SMOOTHER_ASSERT_SVH
`define BEZIER_POSITION_SMOOTHER_ASSERT_SVH

// Checked only while the block is out of reset.
`define BPS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bezier_position_smoother: assertion failed");

// Checked at every edge, reset included.
`define BPS_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("bezier_position_smoother: assertion failed");

`endif

[design/bps_pkg.sv]
// Shared constants, codes and control structs of the position smoother.
package bps_pkg;

  localparam int COORD_BITS     = 32;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int CFG_IDX_BITS   = 2;
  localparam int LANE_OP_BITS   = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FILTER_ENABLE   = 2'd0,
    CFG_CURVE_PARAM     = 2'd1,
    CFG_PREDICTION_GAIN = 2'd2,
    CFG_CURVE_GAIN      = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_e;

  typedef enum logic [LANE_OP_BITS-1:0] {
    OP_C1 = 3'd0,
    OP_C2 = 3'd1,
    OP_A  = 3'd2,
    OP_B  = 3'd3,
    OP_D  = 3'd4,
    OP_E  = 3'd5,
    OP_F  = 3'd6,
    OP_R  = 3'd7
  } op_e;

  typedef struct packed {
    logic start;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

  typedef struct packed {
    logic load;
    logic use_lane;
  } merge_ctrl_t;

endpackage

[design/bps_if.sv]
// Handshake channel interfaces for samples, results and configuration writes.
interface bps_in_if #(
  parameter int COORD_BITS = bps_pkg::COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] x_pos;
  logic signed [COORD_BITS-1:0] y_pos;
  logic                         sample_valid;

  modport source (output valid, mode, x_pos, y_pos, sample_valid, input ready);
  modport sink (input valid, mode, x_pos, y_pos, sample_valid, output ready);
endinterface

interface bps_out_if #(
  parameter int COORD_BITS = bps_pkg::COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;

  modport source (output valid, out_x, out_y, input ready);
  modport sink (input valid, out_x, out_y, output ready);
endinterface

interface bps_cfg_if #(
  parameter int GAIN_FRAC_BITS = bps_pkg::GAIN_FRAC_BITS
);
  logic                              valid;
  logic                              ready;
  logic [bps_pkg::CFG_IDX_BITS-1:0]  index;
  logic [GAIN_FRAC_BITS+1:0]         data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/bps_lane.sv]
// One axis lane: control points and de Casteljau steps on a shared multiplier.
module bps_lane #(
  parameter int COORD_BITS     = bps_pkg::COORD_BITS,
  parameter int GAIN_FRAC_BITS = bps_pkg::GAIN_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bps_pkg::lane_ctrl_t           ctrl_i,
  input  logic signed [COORD_BITS-1:0]  p0_i,
  input  logic signed [COORD_BITS-1:0]  p1_i,
  input  logic signed [COORD_BITS-1:0]  p2_i,
  input  logic signed [COORD_BITS-1:0]  p3_i,
  input  logic [GAIN_FRAC_BITS+1:0]     c_i,
  input  logic [GAIN_FRAC_BITS+1:0]     k_i,
  input  logic [GAIN_FRAC_BITS+1:0]     t_i,
  output bps_pkg::lane_stat_t           stat_o,
  output logic signed [COORD_BITS-1:0]  res_o
);

  localparam int W  = COORD_BITS + 4;
  localparam int DW = W + 1;
  localparam int GW = GAIN_FRAC_BITS + 2;
  localparam int PW = DW + GW;
  localparam int QW = PW - GAIN_FRAC_BITS;
  localparam int SW = QW + 1;
  localparam int XW = W - COORD_BITS + 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (GAIN_FRAC_BITS - 1);
  localparam logic [bps_pkg::LANE_OP_BITS-1:0] LANE_OP_BITS_ONE =
    bps_pkg::LANE_OP_BITS'(1);

  logic signed [W-1:0] p0_w, p1_w, p2_w, p3_w;
  logic signed [W-1:0] c1_q, c2_q, a_q, b_q, d_q, e_q, f_q, r_q;
  logic signed [W-1:0] base_d, base_q, hi, lo;
  logic signed [DW-1:0] diff_d, diff_q;
  logic [GW-1:0] gain_d, gain_q;
  bps_pkg::op_e step_q, step_d;
  logic phase_q, busy_q, done_q;

  logic [DW-1:0] mag;
  logic [PW-1:0] prod;
  logic [QW-1:0] qv;
  logic signed [SW-1:0] sum;
  logic signed [W-1:0] res_w;
  logic [XW-1:0] top_bits;

  assign p0_w = {{(W-COORD_BITS){p0_i[COORD_BITS-1]}}, p0_i};
  assign p1_w = {{(W-COORD_BITS){p1_i[COORD_BITS-1]}}, p1_i};
  assign p2_w = {{(W-COORD_BITS){p2_i[COORD_BITS-1]}}, p2_i};
  assign p3_w = {{(W-COORD_BITS){p3_i[COORD_BITS-1]}}, p3_i};

  always_comb begin
    base_d = '0;
    hi     = '0;
    lo     = '0;
    gain_d = t_i;
    case (step_q)
      bps_pkg::OP_C1: begin base_d = p1_w; hi = p2_w; lo = p0_w; gain_d = c_i; end
      bps_pkg::OP_C2: begin base_d = p2_w; hi = p3_w; lo = p2_w; gain_d = k_i; end
      bps_pkg::OP_A:  begin base_d = p1_w; hi = c1_q; lo = p1_w; end
      bps_pkg::OP_B:  begin base_d = c1_q; hi = c2_q; lo = c1_q; end
      bps_pkg::OP_D:  begin base_d = c2_q; hi = p3_w; lo = c2_q; end
      bps_pkg::OP_E:  begin base_d = a_q;  hi = b_q;  lo = a_q;  end
      bps_pkg::OP_F:  begin base_d = b_q;  hi = d_q;  lo = b_q;  end
      bps_pkg::OP_R:  begin base_d = e_q;  hi = f_q;  lo = e_q;  end
      default: begin base_d = '0; hi = '0; lo = '0; end
    endcase
    diff_d = {hi[W-1], hi} - {lo[W-1], lo};
  end

  // The product is rounded on the magnitude, ties away from zero.
  always_comb begin
    mag  = diff_q[DW-1] ? DW'(-diff_q) : DW'(diff_q);
    prod = PW'(mag) * PW'(gain_q) + HALF;
    qv   = prod[PW-1:GAIN_FRAC_BITS];
    if (diff_q[DW-1]) begin
      sum = SW'(base_q) - $signed({1'b0, qv});
    end else begin
      sum = SW'(base_q) + $signed({1'b0, qv});
    end
    res_w = sum[W-1:0];
  end

  assign step_d = bps_pkg::op_e'(step_q + LANE_OP_BITS_ONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= bps_pkg::OP_C1;
      phase_q <= 1'b0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        step_q  <= bps_pkg::OP_C1;
        phase_q <= 1'b0;
        busy_q  <= 1'b1;
      end else if (busy_q) begin
        phase_q <= ~phase_q;
        if (phase_q) begin
          if (step_q == bps_pkg::OP_R) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            step_q <= step_d;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !phase_q) begin
      base_q <= base_d;
      diff_q <= diff_d;
      gain_q <= gain_d;
    end
    if (busy_q && phase_q) begin
      case (step_q)
        bps_pkg::OP_C1: c1_q <= res_w;
        bps_pkg::OP_C2: c2_q <= res_w;
        bps_pkg::OP_A:  a_q  <= res_w;
        bps_pkg::OP_B:  b_q  <= res_w;
        bps_pkg::OP_D:  d_q  <= res_w;
        bps_pkg::OP_E:  e_q  <= res_w;
        bps_pkg::OP_F:  f_q  <= res_w;
        bps_pkg::OP_R:  r_q  <= res_w;
        default: r_q <= r_q;
      endcase
    end
  end

  // Saturate the final point to the coordinate range.
  assign top_bits = r_q[W-1:COORD_BITS-1];
  always_comb begin
    if ((top_bits == '0) || (top_bits == '1)) begin
      res_o = r_q[COORD_BITS-1:0];
    end else if (r_q[W-1]) begin
      res_o = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      res_o = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

[design/bps_merge.sv]
// Output stage: pairs the two lane results, or a passed sample, into one beat.
module bps_merge #(
  parameter int COORD_BITS = bps_pkg::COORD_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bps_pkg::merge_ctrl_t          ctrl_i,
  input  logic signed [COORD_BITS-1:0]  lane_x_i,
  input  logic signed [COORD_BITS-1:0]  lane_y_i,
  input  logic signed [COORD_BITS-1:0]  pass_x_i,
  input  logic signed [COORD_BITS-1:0]  pass_y_i,
  output logic                          ready_o,
  bps_out_if.source                     out_o
);

  logic                         out_valid_q;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q;

  assign ready_o = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load && ready_o) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && ready_o) begin
      out_x_q <= ctrl_i.use_lane ? lane_x_i : pass_x_i;
      out_y_q <= ctrl_i.use_lane ? lane_y_i : pass_y_i;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.out_x = out_x_q;
  assign out_o.out_y = out_y_q;

endmodule

[design/bezier_position_smoother.sv]
// Cubic Bezier pen position smoother with one lane per axis.
// A smoothed sample runs the eight multiply steps of each lane before its result beat
// is loaded into the output stage, and no new sample is accepted until then.
// A passed-through sample skips the lanes, and a reset-mode sample gives no result beat.
// Reset clears the history, the primed flag and the output valid, and loads the
// register defaults; no clearing pass is needed.
module bezier_position_smoother #(
  parameter int COORD_BITS     = bps_pkg::COORD_BITS,
  parameter int GAIN_FRAC_BITS = bps_pkg::GAIN_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bps_cfg_if.sink     cfg_i,
  bps_in_if.sink      in_i,
  bps_out_if.source   out_o
);

  localparam int G  = GAIN_FRAC_BITS;
  localparam int GW = G + 2;
  localparam logic [GW-1:0] ONE      = GW'(1) << G;
  localparam logic [GW-1:0] TWO      = GW'(2) << G;
  localparam logic [GW-1:0] HALF_ONE = GW'(1) << (G - 1);
  localparam logic [GW-1:0] T_MIN    = GW'((longint'(1) << G) / 100);
  localparam logic [GW-1:0] PRED_RST = GW'((longint'(22938) << G) >> 16);
  localparam int KW = 2 * GW;

  logic          filter_enable_q;
  logic [G:0]    curve_param_q;
  logic [G+1:0]  prediction_gain_q;
  logic [G:0]    curve_gain_q;

  logic [GW-1:0] c_d, p_d, t_d, c_q, k_q, t_q;
  logic [KW-1:0] k_prod;

  logic signed [COORD_BITS-1:0] hist_x_q [4];
  logic signed [COORD_BITS-1:0] hist_y_q [4];
  logic signed [COORD_BITS-1:0] pass_x_q, pass_y_q;
  logic signed [COORD_BITS-1:0] lane_x, lane_y;
  logic primed_q, use_lane_q;

  bps_pkg::state_e      state_q, state_d;
  bps_pkg::lane_ctrl_t  lane_ctrl;
  bps_pkg::lane_stat_t  stat_x, stat_y;
  bps_pkg::merge_ctrl_t merge_ctrl;
  logic merge_ready;
  logic in_fire, do_smooth, do_pass;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_enable_q   <= 1'b1;
      curve_param_q     <= HALF_ONE[G:0];
      prediction_gain_q <= PRED_RST;
      curve_gain_q      <= HALF_ONE[G:0];
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bps_pkg::CFG_FILTER_ENABLE:   filter_enable_q   <= cfg_i.data[0];
        bps_pkg::CFG_CURVE_PARAM:     curve_param_q     <= cfg_i.data[G:0];
        bps_pkg::CFG_PREDICTION_GAIN: prediction_gain_q <= cfg_i.data[G+1:0];
        bps_pkg::CFG_CURVE_GAIN:      curve_gain_q      <= cfg_i.data[G:0];
        default: filter_enable_q <= filter_enable_q;
      endcase
    end
  end

  // Gains are clamped and the prediction product is formed ahead of any sample.
  always_comb begin
    c_d = (GW'(curve_gain_q) > ONE) ? ONE : GW'(curve_gain_q);
    p_d = (prediction_gain_q > TWO) ? TWO : prediction_gain_q;
    if (GW'(curve_param_q) > ONE) begin
      t_d = ONE;
    end else if (GW'(curve_param_q) < T_MIN) begin
      t_d = T_MIN;
    end else begin
      t_d = GW'(curve_param_q);
    end
    k_prod = KW'(p_d) * KW'(c_d) + KW'(HALF_ONE);
  end

  always_ff @(posedge clk_i) begin
    c_q <= c_d;
    t_q <= t_d;
    k_q <= k_prod[G+GW-1:G];
  end

  assign in_fire   = in_i.valid && in_i.ready;
  assign do_smooth = in_fire && !in_i.mode && in_i.sample_valid && filter_enable_q;
  assign do_pass   = in_fire && !in_i.mode && !(in_i.sample_valid && filter_enable_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        hist_x_q[i] <= '0;
        hist_y_q[i] <= '0;
      end
    end else if ((in_fire && in_i.mode) || (do_smooth && !primed_q)) begin
      primed_q <= 1'b1;
      for (int i = 0; i < 4; i++) begin
        hist_x_q[i] <= in_i.x_pos;
        hist_y_q[i] <= in_i.y_pos;
      end
    end else if (do_smooth) begin
      for (int i = 0; i < 3; i++) begin
        hist_x_q[i] <= hist_x_q[i+1];
        hist_y_q[i] <= hist_y_q[i+1];
      end
      hist_x_q[3] <= in_i.x_pos;
      hist_y_q[3] <= in_i.y_pos;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_pass) begin
      pass_x_q <= in_i.x_pos;
      pass_y_q <= in_i.y_pos;
    end
    if (in_fire) begin
      use_lane_q <= do_smooth;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      bps_pkg::ST_IDLE: begin
        if (do_smooth) begin
          state_d = bps_pkg::ST_CALC;
        end else if (do_pass) begin
          state_d = bps_pkg::ST_EMIT;
        end
      end
      bps_pkg::ST_CALC: begin
        if (stat_x.done && stat_y.done) begin
          state_d = bps_pkg::ST_EMIT;
        end
      end
      bps_pkg::ST_EMIT: begin
        if (merge_ready) begin
          state_d = bps_pkg::ST_IDLE;
        end
      end
      default: state_d = bps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bps_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    in_i.ready          = 1'b0;
    merge_ctrl.load     = 1'b0;
    merge_ctrl.use_lane = use_lane_q;
    lane_ctrl.start     = 1'b0;
    case (state_q)
      bps_pkg::ST_IDLE: begin
        in_i.ready      = 1'b1;
        lane_ctrl.start = do_smooth;
      end
      bps_pkg::ST_EMIT: merge_ctrl.load = 1'b1;
      default: merge_ctrl.load = 1'b0;
    endcase
  end

  bps_lane #(
    .COORD_BITS    (COORD_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_lane_x (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(lane_ctrl),
    .p0_i  (hist_x_q[0]),
    .p1_i  (hist_x_q[1]),
    .p2_i  (hist_x_q[2]),
    .p3_i  (hist_x_q[3]),
    .c_i   (c_q),
    .k_i   (k_q),
    .t_i   (t_q),
    .stat_o(stat_x),
    .res_o (lane_x)
  );

  bps_lane #(
    .COORD_BITS    (COORD_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_lane_y (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(lane_ctrl),
    .p0_i  (hist_y_q[0]),
    .p1_i  (hist_y_q[1]),
    .p2_i  (hist_y_q[2]),
    .p3_i  (hist_y_q[3]),
    .c_i   (c_q),
    .k_i   (k_q),
    .t_i   (t_q),
    .stat_o(stat_y),
    .res_o (lane_y)
  );

  bps_merge #(
    .COORD_BITS(COORD_BITS)
  ) u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (merge_ctrl),
    .lane_x_i(lane_x),
    .lane_y_i(lane_y),
    .pass_x_i(pass_x_q),
    .pass_y_i(pass_y_q),
    .ready_o (merge_ready),
    .out_o   (out_o)
  );

endmodule

[design/bps_checker.sv]
// Port-level checker of the position smoother and its bind statement.
`include "bezier_position_smoother_assert.svh"

module bps_checker #(
  parameter int COORD_BITS = bps_pkg::COORD_BITS
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  in_mode_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [COORD_BITS-1:0] out_x_i,
  input logic [COORD_BITS-1:0] out_y_i
);

  // Any processed beat keeps the block busy for at least the following cycle.
  `BPS_ASSERT(a_busy_after_process, clk_i, rst_ni,
    (in_valid_i && in_ready_i && !in_mode_i) |=> !in_ready_i)

  `BPS_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |=> !out_valid_i)

  `BPS_ASSERT(a_out_valid_holds, clk_i, rst_ni,
    (out_valid_i && !out_ready_i) |=> out_valid_i)

  `BPS_ASSERT(a_out_data_holds, clk_i, rst_ni,
    (out_valid_i && !out_ready_i) |=> ($stable(out_x_i) && $stable(out_y_i)))

endmodule

bind bezier_position_smoother bps_checker #(
  .COORD_BITS(COORD_BITS)
) u_bps_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .in_mode_i  (in_i.mode),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_x_i    (out_o.out_x),
  .out_y_i    (out_o.out_y)
);

[sim/bezier_position_smoother_checker.sv]
// Checker that predicts the smoothed pen positions and compares them with the result channel.
`timescale 1ns / 100ps

module bezier_position_smoother_checker
  import bps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  bps_cfg_if          cfg_mon,
  bps_in_if           smp_mon,
  bps_out_if          res_mon,
  output int unsigned pending_o,
  output int unsigned fail_count_o
);

  localparam int CB = COORD_BITS;
  localparam int GFB = GAIN_FRAC_BITS;
  localparam longint unsigned ONE = 64'd1 << GFB;
  localparam longint unsigned HALF = ONE >> 1;
  localparam longint unsigned T_FLOOR = ONE / 100;
  localparam longint COORD_MAX = (64'sd1 <<< (CB - 1)) - 64'sd1;
  localparam longint COORD_MIN = -COORD_MAX - 64'sd1;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
  } pen_point_t;

  pen_point_t        smoothed_q[$];
  longint            trail_x[4];
  longint            trail_y[4];
  bit                primed;
  logic              filt_en;
  logic [GFB:0]      t_raw;
  logic [GFB+1:0]    pred_raw;
  logic [GFB:0]      curv_raw;
  int unsigned       mismatches;

  // Gain product as sign and magnitude, rounded to nearest with ties away from zero.
  function automatic longint scale_round(longint a, longint unsigned g);
    longint unsigned mag;
    longint unsigned q;
    mag = (a < 0) ? longint'(-a) : a;
    q = (mag >> GFB) * g + (((mag & (ONE - 1)) * g + HALF) >> GFB);
    return (a < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint blend(longint a, longint b, longint unsigned t);
    return a + scale_round(b - a, t);
  endfunction

  function automatic logic [CB-1:0] bezier_axis(longint h0, longint h1, longint h2,
                                                longint h3, longint unsigned c,
                                                longint unsigned k, longint unsigned t);
    longint q1;
    longint q2;
    longint a;
    longint b;
    longint d;
    longint e;
    longint f;
    longint r;
    q1 = h1 + scale_round(h2 - h0, c);
    q2 = h2 + scale_round(h3 - h2, k);
    a = blend(h1, q1, t);
    b = blend(q1, q2, t);
    d = blend(q2, h3, t);
    e = blend(a, b, t);
    f = blend(b, d, t);
    r = blend(e, f, t);
    if (r > COORD_MAX) r = COORD_MAX;
    if (r < COORD_MIN) r = COORD_MIN;
    return r[CB-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [CB-1:0] got, logic [CB-1:0] want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    end
  endtask

  task automatic apply_register(logic [CFG_IDX_BITS-1:0] idx, logic [GFB+1:0] data);
    case (cfg_idx_e'(idx))
      CFG_FILTER_ENABLE: begin
        filt_en = data[0];
      end
      CFG_CURVE_PARAM: begin
        t_raw = data[GFB:0];
      end
      CFG_PREDICTION_GAIN: begin
        pred_raw = data;
      end
      CFG_CURVE_GAIN: begin
        curv_raw = data[GFB:0];
      end
      default: begin
      end
    endcase
  endtask

  task automatic take_sample(logic mode, logic signed [CB-1:0] x, logic signed [CB-1:0] y,
                             logic sample_ok);
    longint          sx;
    longint          sy;
    longint unsigned c;
    longint unsigned p;
    longint unsigned k;
    longint unsigned t;
    pen_point_t      res;
    sx = x;
    sy = y;
    if (mode) begin
      for (int i = 0; i < 4; i++) begin
        trail_x[i] = sx;
        trail_y[i] = sy;
      end
      primed = 1'b1;
    end else if (!sample_ok || !filt_en) begin
      res.x = x;
      res.y = y;
      smoothed_q.push_back(res);
    end else begin
      for (int i = 0; i < 4; i++) begin
        trail_x[i] = (primed && i < 3) ? trail_x[i+1] : sx;
        trail_y[i] = (primed && i < 3) ? trail_y[i+1] : sy;
      end
      primed = 1'b1;
      c = (curv_raw > ONE) ? ONE : curv_raw;
      p = (pred_raw > 2 * ONE) ? 2 * ONE : pred_raw;
      k = (p * c + HALF) >> GFB;
      t = (t_raw < T_FLOOR) ? T_FLOOR : ((t_raw > ONE) ? ONE : t_raw);
      res.x = bezier_axis(trail_x[0], trail_x[1], trail_x[2], trail_x[3], c, k, t);
      res.y = bezier_axis(trail_y[0], trail_y[1], trail_y[2], trail_y[3], c, k, t);
      smoothed_q.push_back(res);
    end
  endtask

  task automatic check_result(logic [CB-1:0] got_x, logic [CB-1:0] got_y);
    pen_point_t want;
    if (smoothed_q.size() == 0) begin
      report_mismatch("result beat with nothing pending", got_x, 'x);
    end else begin
      want = smoothed_q.pop_front();
      if (got_x !== want.x) report_mismatch("out_x", got_x, want.x);
      if (got_y !== want.y) report_mismatch("out_y", got_y, want.y);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        trail_x[i] = 0;
        trail_y[i] = 0;
      end
      primed = 1'b0;
      filt_en = 1'b1;
      t_raw = ONE / 2;
      pred_raw = 22938;
      curv_raw = ONE / 2;
      mismatches = 0;
      smoothed_q.delete();
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) apply_register(cfg_mon.index, cfg_mon.data);
      if (smp_mon.valid && smp_mon.ready) begin
        take_sample(smp_mon.mode, smp_mon.x_pos, smp_mon.y_pos, smp_mon.sample_valid);
      end
      if (res_mon.valid && res_mon.ready) check_result(res_mon.out_x, res_mon.out_y);
      pending_o <= smoothed_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[sim/tb_bezier_position_smoother.sv]
// Testbench top for the pen position smoother: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_bezier_position_smoother;
  import bps_pkg::*;

  localparam logic        MODE_PROCESS = 1'b0;
  localparam logic        MODE_SEED    = 1'b1;
  localparam logic [31:0] PEN_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] PEN_MIN      = 32'h8000_0000;
  localparam int          SETTLE       = 24;
  localparam int          LONG_HOLD    = 500;
  localparam int          STALL_LIMIT  = 4000;

  logic        clk;
  logic        rst_n;
  logic        calm;
  int unsigned hold_token;
  int unsigned hold_seen;
  int unsigned rx_hold;
  int unsigned rx_wait;
  int unsigned idle_cycles;
  int unsigned pending_cnt;
  int unsigned fail_cnt;
  logic [31:0] pen_x;
  logic [31:0] pen_y;

  bps_cfg_if cfg_bus ();
  bps_in_if  smp_bus ();
  bps_out_if res_bus ();

  bezier_position_smoother u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .in_i   (smp_bus),
    .out_o  (res_bus)
  );

  bezier_position_smoother_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_mon      (cfg_bus),
    .smp_mon      (smp_bus),
    .res_mon      (res_bus),
    .pending_o    (pending_cnt),
    .fail_count_o (fail_cnt)
  );

  always #1 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
      rx_hold <= 0;
      rx_wait <= 0;
      hold_seen <= 0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      rx_hold <= LONG_HOLD;
      res_bus.ready <= 1'b0;
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      res_bus.ready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait <= rx_wait - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
      rx_wait <= calm ? 0 : pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((cfg_bus.valid && cfg_bus.ready) || (smp_bus.valid && smp_bus.ready) ||
                 (res_bus.valid && res_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_sample(logic m, logic [31:0] x, logic [31:0] y, logic sample_ok);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      smp_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_bus.valid <= 1'b1;
    smp_bus.mode <= m;
    smp_bus.x_pos <= x;
    smp_bus.y_pos <= y;
    smp_bus.sample_valid <= sample_ok;
    do @(posedge clk); while (!smp_bus.ready);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [GAIN_FRAC_BITS+1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    do @(posedge clk); while (!cfg_bus.ready);
  endtask

  task automatic apply_settings(logic [17:0] en, logic [17:0] t, logic [17:0] pg,
                                logic [17:0] cg);
    write_reg(CFG_FILTER_ENABLE, en);
    write_reg(CFG_CURVE_PARAM, t);
    write_reg(CFG_PREDICTION_GAIN, pg);
    write_reg(CFG_CURVE_GAIN, cg);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    smp_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] next_coord(logic [31:0] cur);
    int unsigned r;
    int unsigned span;
    logic [31:0] step;
    r = $urandom_range(0, 99);
    span = $urandom_range(2, 22);
    step = $urandom & ((32'd1 << span) - 1);
    if (r < 70) return $urandom_range(0, 1) ? cur + step : cur - step;
    if (r < 85) return $urandom;
    if (r < 93) return $urandom_range(0, 1) ? PEN_MAX : PEN_MIN;
    if (r < 97) return cur;
    return '0;
  endfunction

  task automatic random_samples(int n);
    int unsigned r;
    logic m;
    logic sample_ok;
    repeat (n) begin
      r = $urandom_range(0, 99);
      m = (r < 5) ? MODE_SEED : MODE_PROCESS;
      sample_ok = (r < 5) ? 1'($urandom) : (r >= 15);
      pen_x = next_coord(pen_x);
      pen_y = next_coord(pen_y);
      send_sample(m, pen_x, pen_y, sample_ok);
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    calm = 1'b0;
    hold_token = 0;
    pen_x = '0;
    pen_y = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_FILTER_ENABLE;
    cfg_bus.data = '0;
    smp_bus.valid = 1'b0;
    smp_bus.mode = MODE_PROCESS;
    smp_bus.x_pos = '0;
    smp_bus.y_pos = '0;
    smp_bus.sample_valid = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // The first processed sample fills the whole history.
    send_sample(MODE_PROCESS, 32'd25600, -32'sd12800, 1'b1);
    send_sample(MODE_PROCESS, 32'd30720, -32'sd10240, 1'b1);
    send_sample(MODE_PROCESS, PEN_MIN, PEN_MAX, 1'b0);
    send_sample(MODE_SEED, PEN_MIN, PEN_MAX, 1'b0);
    repeat (3) send_sample(MODE_PROCESS, PEN_MAX, PEN_MIN, 1'b1);
    send_sample(MODE_SEED, PEN_MAX, PEN_MIN, 1'b1);
    repeat (3) send_sample(MODE_PROCESS, PEN_MIN, PEN_MAX, 1'b1);
    send_sample(MODE_PROCESS, '0, '0, 1'b1);
    send_sample(MODE_PROCESS, 32'hFFFF_FFFF, 32'd1, 1'b1);
    send_sample(MODE_PROCESS, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    send_sample(MODE_PROCESS, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
    hold_token <= hold_token + 1;
    random_samples(150);
    drain();

    apply_settings(18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    random_samples(180);
    drain();

    apply_settings(18'h3FFFE, 18'h0, 18'h0, 18'h0);
    send_sample(MODE_PROCESS, PEN_MAX, PEN_MIN, 1'b1);
    send_sample(MODE_PROCESS, 32'h1234_5678, 32'hFEDC_BA98, 1'b1);
    random_samples(100);
    drain();

    apply_settings(18'h1, 18'h0, 18'h0, 18'h0);
    random_samples(180);
    drain();

    calm <= 1'b1;
    apply_settings(18'h1, 18'd65536, 18'd131072, 18'd65536);
    random_samples(200);
    drain();
    calm <= 1'b0;

    apply_settings(18'h1, 18'd655, 18'd22938, 18'd32768);
    hold_token <= hold_token + 1;
    random_samples(180);
    drain();

    repeat (5) begin
      apply_settings(($urandom_range(0, 7) != 0) ? 18'h1 : 18'h0,
                     $urandom_range(0, 1) ? 18'($urandom) : 18'($urandom_range(0, 65536)),
                     $urandom_range(0, 1) ? 18'($urandom) : 18'($urandom_range(0, 131072)),
                     $urandom_range(0, 1) ? 18'($urandom) : 18'($urandom_range(0, 65536)));
      random_samples(160);
      drain();
    end

    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
